[design/ialu_pkg.sv]
// package: operation codes, class and packed control types, and default sizes for the integer alu
`timescale 1ns / 1ps
package ialu_pkg;
    localparam int DataWidthDefault = 32;
    localparam int QueueDepthDefault = 4;

    typedef enum logic [3:0] {
        OP_MOV = 4'd0,
        OP_ADD = 4'd1,
        OP_SUB = 4'd2,
        OP_MUL = 4'd3,
        OP_DIV = 4'd4,
        OP_CMP = 4'd5,
        OP_AND = 4'd6,
        OP_OR  = 4'd7,
        OP_XOR = 4'd8,
        OP_SHL = 4'd9,
        OP_SHR = 4'd10,
        OP_SAR = 4'd11,
        OP_LDH = 4'd12,
        OP_LDL = 4'd13
    } t_op;

    // operation class decided by the front end
    typedef enum logic [2:0] {
        CL_NONE  = 3'b000,
        CL_SIMPLE = 3'b001,
        CL_MUL   = 3'b010,
        CL_DIV   = 3'b100
    } t_class;

    typedef struct packed {
        logic   wr;
        logic   fl;
        logic   cmp;
        logic   dz;
        t_class cls;
    } t_ctl;
endpackage

[design/ialu_front.sv]
// front end: accepts words, classifies the operation and computes simple results
`timescale 1ns / 1ps
module ialu_front #(
    parameter int DATA_WIDTH = ialu_pkg::DataWidthDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [3:0]            i_mode,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ialu_pkg::t_ctl        o_ctl,
    output logic [DATA_WIDTH-1:0] o_a,
    output logic [DATA_WIDTH-1:0] o_b,
    output logic [DATA_WIDTH-1:0] o_res
);
    import ialu_pkg::*;
    localparam int Half = DATA_WIDTH / 2;
    localparam int ShW = $clog2(DATA_WIDTH);

    logic                  r_valid;
    t_ctl                  r_ctl, n_ctl;
    logic [DATA_WIDTH-1:0] r_a, r_b, r_res, n_res;
    logic                  big;
    logic [ShW-1:0]        sh;

    assign big = i_b >= DATA_WIDTH'(DATA_WIDTH);
    assign sh  = i_b[ShW-1:0];

    always_comb begin
        n_res = i_a;
        n_ctl = '{wr: 1'b1, fl: 1'b1, cmp: 1'b0, dz: 1'b0, cls: CL_SIMPLE};
        case (i_mode)
            OP_MOV: n_res = i_b;
            OP_ADD: n_res = i_a + i_b;
            OP_SUB: n_res = i_a - i_b;
            OP_MUL: n_ctl.cls = CL_MUL;
            OP_DIV: begin
                n_ctl.fl = 1'b0;
                if (i_b == '0) begin
                    n_ctl.wr = 1'b0;
                    n_ctl.dz = 1'b1;
                end else begin
                    n_ctl.cls = CL_DIV;
                end
            end
            OP_CMP: begin
                n_ctl.wr  = 1'b0;
                n_ctl.cmp = 1'b1;
            end
            OP_AND: n_res = i_a & i_b;
            OP_OR:  n_res = i_a | i_b;
            OP_XOR: n_res = i_a ^ i_b;
            OP_SHL: n_res = big ? '0 : (i_a << sh);
            OP_SHR: n_res = big ? '0 : (i_a >> sh);
            OP_SAR: n_res = big ? {DATA_WIDTH{i_a[DATA_WIDTH-1]}}
                                : DATA_WIDTH'($signed(i_a) >>> sh);
            OP_LDH: begin
                n_res = {i_b[Half-1:0], i_a[Half-1:0]};
                n_ctl.fl = 1'b0;
            end
            OP_LDL: begin
                n_res = {i_a[DATA_WIDTH-1:Half], i_b[Half-1:0]};
                n_ctl.fl = 1'b0;
            end
            default: begin
                n_ctl = '{wr: 1'b0, fl: 1'b0, cmp: 1'b0, dz: 1'b0, cls: CL_NONE};
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_ctl <= n_ctl;
            r_a   <= i_a;
            r_b   <= i_b;
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_res   = r_res;
endmodule

[design/ialu_queue.sv]
// short queue between the front end and the execution back end
`timescale 1ns / 1ps
module ialu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ialu_pkg::QueueDepthDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             push, pop;

    assign o_ready = r_cnt < (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) r_mem[r_wp] <= i_data;
    end
endmodule

[design/ialu_back.sv]
// back end: pipelined multiply and divide, flag generation, output register
`timescale 1ns / 1ps
module ialu_back #(
    parameter int DATA_WIDTH = ialu_pkg::DataWidthDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  ialu_pkg::t_ctl        i_ctl,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    input  logic [DATA_WIDTH-1:0] i_res,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_WIDTH-1:0] o_result,
    output logic [DATA_WIDTH-1:0] o_remainder,
    output logic [7:0]            o_bits
);
    import ialu_pkg::*;
    localparam int W = DATA_WIDTH;
    localparam int NS = W + 1;      // one stage per quotient bit plus a fixup stage
    localparam int HW = W / 2;

    // per-stage payload: divide uses q/r/d, multiply uses partial products
    logic             r_v   [NS+1];
    t_ctl             r_ctl [NS+1];
    logic [W-1:0]     r_a   [NS+1];
    logic [W-1:0]     r_b   [NS+1];
    logic [W-1:0]     r_res [NS+1];
    logic [W-1:0]     r_rm  [NS+1];
    logic [W-1:0]     r_q   [NS+1];
    logic             adv;
    logic             r_ov;
    logic [W-1:0]     r_or, r_orem;
    logic [7:0]       r_ob;

    // the pipeline moves as a whole; a full output register that is not taken stalls it
    assign adv     = !r_ov || i_ready;
    assign o_ready = adv;

    logic [W-1:0] ua, ub;
    assign ua = i_a[W-1] ? W'(-i_a) : i_a;
    assign ub = i_b[W-1] ? W'(-i_b) : i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) r_v[k] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= NS; k++) r_v[k] <= r_v[k-1];
        end
    end

    // stage 0: operand magnitudes (divide) or low partial products (multiply)
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ctl[0] <= i_ctl;
            r_a[0]   <= i_a;
            r_b[0]   <= i_b;
            r_rm[0]  <= '0;
            if (i_ctl.cls == CL_DIV) begin
                r_q[0] <= ua;
                r_res[0] <= ub;
            end else begin
                r_q[0] <= {{HW{1'b0}}, i_a[HW-1:0]} * {{HW{1'b0}}, i_b[HW-1:0]};
                r_res[0] <= i_res;
            end
        end
    end

    // restoring division, one quotient bit per stage; multiply finishes in stage 1
    for (genvar s = 1; s < NS; s++) begin : g_stage
        logic [W:0]   trial;
        logic [W-1:0] shr;
        assign shr   = {r_rm[s-1][W-2:0], r_q[s-1][W-1]};
        assign trial = {1'b0, shr} - {1'b0, r_res[s-1]};
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ctl[s] <= r_ctl[s-1];
                r_a[s]   <= r_a[s-1];
                r_b[s]   <= r_b[s-1];
                if (r_ctl[s-1].cls == CL_DIV) begin
                    r_res[s] <= r_res[s-1];
                    if (!trial[W]) begin
                        r_rm[s] <= trial[W-1:0];
                        r_q[s]  <= {r_q[s-1][W-2:0], 1'b1};
                    end else begin
                        r_rm[s] <= shr;
                        r_q[s]  <= {r_q[s-1][W-2:0], 1'b0};
                    end
                end else if (s == 1 && r_ctl[s-1].cls == CL_MUL) begin
                    r_res[s] <= r_q[s-1]
                        + {HW'(r_a[s-1][W-1:HW] * r_b[s-1][HW-1:0]), {HW{1'b0}}}
                        + {HW'(r_a[s-1][HW-1:0] * r_b[s-1][W-1:HW]), {HW{1'b0}}};
                    r_rm[s]  <= r_rm[s-1];
                    r_q[s]   <= r_q[s-1];
                end else begin
                    r_res[s] <= r_res[s-1];
                    r_rm[s]  <= r_rm[s-1];
                    r_q[s]   <= r_q[s-1];
                end
            end
        end
    end

    // last stage: signs of quotient and remainder
    logic neg_q, neg_r;
    assign neg_q = r_a[NS-1][W-1] ^ r_b[NS-1][W-1];
    assign neg_r = r_a[NS-1][W-1];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ctl[NS] <= r_ctl[NS-1];
            r_a[NS]   <= r_a[NS-1];
            r_b[NS]   <= r_b[NS-1];
            r_q[NS]   <= r_q[NS-1];
            if (r_ctl[NS-1].cls == CL_DIV) begin
                r_res[NS] <= neg_q ? W'(-r_q[NS-1]) : r_q[NS-1];
                r_rm[NS]  <= neg_r ? W'(-r_rm[NS-1]) : r_rm[NS-1];
            end else begin
                r_res[NS] <= r_res[NS-1];
                r_rm[NS]  <= '0;
            end
        end
    end

    // flags and output register
    logic [W-1:0] fsrc;
    t_ctl         c;
    assign c    = r_ctl[NS];
    assign fsrc = c.cmp ? W'(r_a[NS] - r_b[NS]) : r_res[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_v[NS];
        end
        if (adv) begin
            r_or   <= r_res[NS];
            r_orem <= r_rm[NS];
            r_ob   <= {c.dz, c.fl && (fsrc == '0), c.fl && fsrc[W-1], c.fl,
                       c.cls == CL_DIV, c.wr, 2'b00};
        end
    end

    assign o_valid     = r_ov;
    assign o_result    = r_or;
    assign o_remainder = r_orem;
    assign o_bits      = r_ob;
endmodule

[design/integer_alu_with_flags.sv]
// top level: integer alu with condition flags
`timescale 1ns / 1ps
// Integer ALU with negative/zero flags. One word per cycle is accepted while the queue
// has room, and one result word comes out per input word, in order. Every operation
// passes the front register, the queue, the DATA_WIDTH + 2 back-end stages of the
// restoring divider and the output register; words waiting in the queue are held
// longer. Throughput is one word per cycle; a stalled output holds the back end while
// the front keeps filling the queue. s_axis_tdata: mode[3:0], op_first, op_second,
// zero filled. m_axis_tdata: result, remainder, write_first, write_remainder,
// flags_update, negative, zero, div_by_zero, zero filled.
module integer_alu_with_flags #(
    parameter int DATA_WIDTH = ialu_pkg::DataWidthDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // mode[3:0], op_first, op_second
    input  logic [((4 + 2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // result, remainder, write_first, write_remainder, flags_update, negative, zero, div_by_zero
    output logic [((2 * DATA_WIDTH + 6 + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    import ialu_pkg::*;
    localparam int W = DATA_WIDTH;
    localparam int OW = ((2 * W + 6 + 7) / 8) * 8;
    localparam int QW = $bits(t_ctl) + 3 * W;

    logic         f_valid, f_ready, q_valid, q_ready;
    t_ctl         f_ctl, q_ctl;
    logic [W-1:0] f_a, f_b, f_res, q_a, q_b, q_res;
    logic [W-1:0] b_res, b_rem;
    logic [7:0]   b_bits;

    ialu_front #(.DATA_WIDTH(W)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_mode(s_axis_tdata[3:0]), .i_a(s_axis_tdata[4 +: W]),
        .i_b(s_axis_tdata[4 + W +: W]),
        .o_valid(f_valid), .i_ready(f_ready),
        .o_ctl(f_ctl), .o_a(f_a), .o_b(f_b), .o_res(f_res)
    );

    ialu_queue #(.WIDTH(QW), .DEPTH(QueueDepthDefault)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data({f_ctl, f_a, f_b, f_res}),
        .o_valid(q_valid), .i_ready(q_ready), .o_data({q_ctl, q_a, q_b, q_res})
    );

    ialu_back #(.DATA_WIDTH(W)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready),
        .i_ctl(q_ctl), .i_a(q_a), .i_b(q_b), .i_res(q_res),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_result(b_res), .o_remainder(b_rem), .o_bits(b_bits)
    );

    assign m_axis_tdata = OW'({b_bits[7:2], b_rem, b_res});
endmodule

[dv/integer_alu_with_flags_chk.sv]
// checker: predicts each alu result word and compares it with the output channel
`timescale 1ns / 1ps
module integer_alu_with_flags_chk #(
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    input  logic s_axis_tready,
    input  logic [((4 + 2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  logic [((2 * DATA_WIDTH + 6 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output int   o_fail_count,
    output int   o_pending
);
    import ialu_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int HALF = W / 2;

    typedef struct packed {
        logic         dz;
        logic         zero;
        logic         neg;
        logic         fl;
        logic         wrem;
        logic         wr;
        logic [W-1:0] rem;
        logic [W-1:0] res;
    } t_alu_out;

    t_alu_out expected_q[$];

    function automatic t_alu_out alu_predict(logic [3:0] mode, logic [W-1:0] a,
                                             logic [W-1:0] b);
        t_alu_out o;
        logic [W-1:0] fsrc, ua, ub, q, r;
        logic [W-1:0] lo_mask;
        o = '0;
        o.res = a;
        fsrc = '0;
        lo_mask = {{(W - HALF){1'b0}}, {HALF{1'b1}}};
        case (mode)
            OP_MOV: begin o.res = b; o.wr = 1'b1; o.fl = 1'b1; end
            OP_ADD: begin o.res = a + b; o.wr = 1'b1; o.fl = 1'b1; end
            OP_SUB: begin o.res = a - b; o.wr = 1'b1; o.fl = 1'b1; end
            OP_MUL: begin o.res = a * b; o.wr = 1'b1; o.fl = 1'b1; end
            OP_DIV: begin
                if (b == '0) begin
                    o.dz = 1'b1;
                end else begin
                    ua = a[W-1] ? -a : a;
                    ub = b[W-1] ? -b : b;
                    q = ua / ub;
                    r = ua % ub;
                    o.res = (a[W-1] != b[W-1]) ? -q : q;
                    o.rem = a[W-1] ? -r : r;
                    o.wr = 1'b1;
                    o.wrem = 1'b1;
                end
            end
            OP_CMP: begin fsrc = a - b; o.fl = 1'b1; end
            OP_AND: begin o.res = a & b; o.wr = 1'b1; o.fl = 1'b1; end
            OP_OR:  begin o.res = a | b; o.wr = 1'b1; o.fl = 1'b1; end
            OP_XOR: begin o.res = a ^ b; o.wr = 1'b1; o.fl = 1'b1; end
            OP_SHL: begin o.res = (b >= W) ? '0 : a << b; o.wr = 1'b1; o.fl = 1'b1; end
            OP_SHR: begin o.res = (b >= W) ? '0 : a >> b; o.wr = 1'b1; o.fl = 1'b1; end
            OP_SAR: begin
                if (b >= W) o.res = {W{a[W-1]}};
                else o.res = $signed(a) >>> b;
                o.wr = 1'b1;
                o.fl = 1'b1;
            end
            OP_LDH: begin
                o.res = (a & lo_mask) | ((b & lo_mask) << HALF);
                o.wr = 1'b1;
            end
            OP_LDL: begin o.res = (a & ~lo_mask) | (b & lo_mask); o.wr = 1'b1; end
            default: ;
        endcase
        if (o.fl && mode != OP_CMP) fsrc = o.res;
        o.neg = o.fl & fsrc[W-1];
        o.zero = o.fl & (fsrc == '0);
        return o;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_alu_out got, want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(alu_predict(s_axis_tdata[3:0],
                    s_axis_tdata[4 +: W], s_axis_tdata[4 + W +: W]));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[2 * W + 5:0];
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected: %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (got.res != want.res)
                            $error("result exp %h got %h", want.res, got.res);
                        if (got.rem != want.rem)
                            $error("remainder exp %h got %h", want.rem, got.rem);
                        if (got.wr != want.wr)
                            $error("write_first exp %b got %b", want.wr, got.wr);
                        if (got.wrem != want.wrem)
                            $error("write_remainder exp %b got %b", want.wrem, got.wrem);
                        if (got.fl != want.fl)
                            $error("flags_update exp %b got %b", want.fl, got.fl);
                        if (got.neg != want.neg)
                            $error("negative exp %b got %b", want.neg, got.neg);
                        if (got.zero != want.zero)
                            $error("zero exp %b got %b", want.zero, got.zero);
                        if (got.dz != want.dz)
                            $error("div_by_zero exp %b got %b", want.dz, got.dz);
                    end
                end
            end
        end
    end
endmodule

[dv/integer_alu_with_flags_tb.sv]
// testbench top: drives operation words into the alu and gives the verdict
`timescale 1ns / 1ps
module integer_alu_with_flags_tb;
    import ialu_pkg::*;

    localparam int W = 32;
    localparam int IN_BITS = ((4 + 2 * W + 7) / 8) * 8;
    localparam int OUT_BITS = ((2 * W + 6 + 7) / 8) * 8;
    localparam int N_RANDOM = 1100;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_BITS-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_BITS-1:0] m_axis_tdata;
    int fail_count;
    int pending;
    int cycle_count = 0;
    bit quiet_phase = 0;
    bit long_hold = 0;

    always #5 i_clk = ~i_clk;

    integer_alu_with_flags #(.DATA_WIDTH(W)) u_dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    integer_alu_with_flags_chk #(.DATA_WIDTH(W)) u_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                m_axis_tready <= 0;
                repeat (300) @(posedge i_clk);
                long_hold = 0;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 0;
                n = $urandom_range(1, 17);
                repeat (n) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return 32'hffff_ffff;
            4: return $urandom_range(0, 70);
            5: return -$urandom_range(1, 70);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(logic [3:0] mode, logic [W-1:0] a, logic [W-1:0] b);
        int gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {a, b, mode} == 0 ? '0 : IN_BITS'({b, a, mode});
        @(posedge i_clk iff s_axis_tready);
    endtask

    initial begin
        logic [3:0] mode;
        logic [W-1:0] a, b;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: every operation, extremes and special cases
        for (int op = 0; op < 16; op++)
            send_word(op[3:0], 32'h8000_1234, 32'h0000_0003);
        send_word(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_word(OP_DIV, 32'h1234_5678, 32'h0000_0000);
        send_word(OP_DIV, 32'hffff_fff9, 32'h0000_0002);
        send_word(OP_CMP, 32'h0000_0005, 32'h0000_0005);
        send_word(OP_SHL, 32'hffff_ffff, 32'h0000_0020);
        send_word(OP_SHR, 32'hffff_ffff, 32'h8000_0000);
        send_word(OP_SAR, 32'h8000_0000, 32'h0000_0021);
        send_word(OP_SAR, 32'h7fff_ffff, 32'hffff_ffff);
        send_word(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 300) long_hold = 1;
            if (i == N_RANDOM - 150) quiet_phase = 1;
            mode = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(14, 15))
                                                : 4'($urandom_range(0, 13));
            a = pick_operand();
            b = pick_operand();
            if (mode inside {OP_SHL, OP_SHR, OP_SAR} && $urandom_range(0, 2) != 0)
                b = $urandom_range(0, 40);
            send_word(mode, a, b);
        end
        s_axis_tvalid <= 0;

        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
